### sv/mpi_pkg.sv
// Shared types, constants and arithmetic helpers of the motor parameter identifier.
package mpi_pkg;

  // identification phases as shown on the result word
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT1 = 3'd1,
    PH_RES   = 3'd2,
    PH_IND   = 3'd3,
    PH_WAIT2 = 3'd4,
    PH_FLUX  = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TEST_CURRENT  = 3'd0,
    CFG_TEST_VELOCITY = 3'd1,
    CFG_INTEGRAL_GAIN = 3'd2,
    CFG_PROP_GAIN     = 3'd3,
    CFG_FLUX_TC       = 3'd4,
    CFG_BUS_VOLTAGE   = 3'd5,
    CFG_TICK_PERIOD   = 3'd6
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_PUSH,
    ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5,
    ST_I0, ST_I1, ST_I2, ST_I3, ST_I4, ST_I5, ST_I6, ST_I7, ST_I8,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8,
    ST_F9, ST_F10, ST_F11, ST_F12, ST_FEND
  } st_t;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 48;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  // reset values of the configuration registers
  localparam logic [30:0] TEST_CURRENT_RST  = 31'd131072;
  localparam logic [30:0] TEST_VELOCITY_RST = 31'd3276800;
  localparam logic [30:0] INTEGRAL_GAIN_RST = 31'd131072;
  localparam logic [30:0] PROP_GAIN_RST     = 31'd1310720;
  localparam logic [30:0] FLUX_TC_RST       = 31'd65536;
  localparam logic [30:0] BUS_VOLTAGE_RST   = 31'd1572864;
  localparam logic [31:0] TICK_PERIOD_RST   = 32'd858993;

  localparam logic signed [31:0] RES_RESET  = 32'sd6554;
  localparam logic        [30:0] IND_RESET  = 31'd66;
  localparam logic signed [31:0] FLUX_RESET = 32'sd3604;
  localparam logic signed [33:0] FILT_KEEP  = 34'sd64881;
  localparam logic signed [33:0] FILT_NEW   = 34'sd655;
  localparam logic signed [31:0] MIN_Q      = 32'sd655;
  localparam logic        [30:0] BW_LOW     = 31'd655360;
  localparam logic        [30:0] BW_HIGH    = 31'd16384000;
  localparam logic        [32:0] VEL_MIN    = 33'd6553;
  localparam logic        [30:0] I31MAX     = 31'h7fff_ffff;
  localparam logic        [31:0] T_RES      = 32'h2000_0000;
  localparam logic        [31:0] T_IND      = 32'h1000_0000;
  localparam logic        [31:0] T_FLUX     = 32'h5000_0000;
  localparam logic        [63:0] K_CAP      = 64'h1_0000_0000;
  // ceil(2^38 / 100): x / 100 == (x * RECIP_100) >> 38 for any 31-bit x
  localparam logic signed [33:0] RECIP_100  = 34'sd2748779070;

  localparam logic signed [69:0] S70_MAX = 70'sd2147483647;
  localparam logic signed [69:0] S70_MIN = -70'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > S70_MAX) return 32'sh7fff_ffff;
    else if (v < S70_MIN) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  // floor((a + b + 0.5 LSB) / 2^16), saturated
  function automatic logic signed [31:0] ema_fin(input logic signed [67:0] a,
                                                 input logic signed [67:0] b);
    logic signed [69:0] s;
    s = {{2{a[67]}}, a} + {{2{b[67]}}, b} + 70'sd32768;
    return sat32(s >>> 16);
  endfunction

  // timer step in 2^-28 s, saturating
  function automatic logic [31:0] tmr_add(input logic [31:0] e, input logic [31:0] tp);
    logic [32:0] s;
    s = {1'b0, e} + {5'd0, tp[31:4]};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

endpackage

### sv/mpi_if.sv
// Valid/ready channel interfaces: input word, result word and configuration write.
interface mpi_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic               enable;
  logic signed [31:0] current_fb;
  logic signed [31:0] voltage_fb;
  logic signed [31:0] velocity_fb;
  modport source (output valid, op, enable, current_fb, voltage_fb, velocity_fb,
                  input ready);
  modport sink   (input valid, op, enable, current_fb, voltage_fb, velocity_fb,
                  output ready);
endinterface

interface mpi_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         phase;
  logic               drive_enable;
  logic               current_mode;
  logic [30:0]        current_bandwidth;
  logic signed [31:0] q_command;
  logic [30:0]        resistance;
  logic [30:0]        inductance;
  logic signed [31:0] flux;
  logic               reversed;
  modport source (output valid, phase, drive_enable, current_mode, current_bandwidth,
                  q_command, resistance, inductance, flux, reversed, input ready);
  modport sink   (input valid, phase, drive_enable, current_mode, current_bandwidth,
                  q_command, resistance, inductance, flux, reversed, output ready);
endinterface

interface mpi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/mpi_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module mpi_div
  import mpi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CntW = $clog2(DIV_NUM_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CntW-1:0]      cnt_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] quot_r;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W-1:0] rem_nxt;
  logic                 qbit;

  always_comb begin
    shifted = {rem_r, quot_r[DIV_NUM_W-1]};
    qbit    = (shifted >= {1'b0, den_r});
    rem_nxt = qbit ? DIV_DEN_W'(shifted - {1'b0, den_r}) : shifted[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      quot_r <= req.num;
      den_r  <= req.den;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[DIV_NUM_W-2:0], qbit};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

### sv/motor_parameter_identifier_top.sv
// Motor parameter identifier: tick sequencer with shared multiplier and divider.
// Per word the sequencer runs its phase's states, then ST_PUSH loads the output
//   register once free: idle, wait and done go straight there; resistance divides
//   and its closing tick scales the test voltage; inductance divides on a closing
//   tick with a current step; flux adds two divider passes above the threshold.
// Throughput: one word at a time; the next word is taken once the sequencer is back
//   in idle, even while the previous result word still waits on the output register.
// Reset: synchronous active-low rst_n; config registers return to defaults, estimates too.
module motor_parameter_identifier_top
  import mpi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  mpi_in_if.sink       in_if,
  mpi_out_if.source    out_if,
  mpi_cfg_if.sink      cfg_if
);

  // ---------------- configuration registers ----------------
  logic [30:0] test_cur_r, test_vel_r, ki_r, kp_r, flux_tc_r, bus_r;
  logic [31:0] tick_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_cur_r <= TEST_CURRENT_RST;
      test_vel_r <= TEST_VELOCITY_RST;
      ki_r       <= INTEGRAL_GAIN_RST;
      kp_r       <= PROP_GAIN_RST;
      flux_tc_r  <= FLUX_TC_RST;
      bus_r      <= BUS_VOLTAGE_RST;
      tick_r     <= TICK_PERIOD_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_TEST_CURRENT:  test_cur_r <= cfg_if.data[30:0];
        CFG_TEST_VELOCITY: test_vel_r <= cfg_if.data[30:0];
        CFG_INTEGRAL_GAIN: ki_r       <= cfg_if.data[30:0];
        CFG_PROP_GAIN:     kp_r       <= cfg_if.data[30:0];
        CFG_FLUX_TC:       flux_tc_r  <= cfg_if.data[30:0];
        CFG_BUS_VOLTAGE:   bus_r      <= cfg_if.data[30:0];
        CFG_TICK_PERIOD:   tick_r     <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // ---------------- shared divider ----------------
  div_req_t div_req;
  div_rsp_t div_rsp;

  mpi_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // ---------------- state ----------------
  st_t    state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic [31:0]        elapsed_r, elapsed_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic [30:0]        ind_r, ind_nxt;
  logic signed [31:0] flux_r, flux_nxt;
  logic               rev_r, rev_nxt;
  logic signed [31:0] cmd_r, cmd_nxt;
  logic [30:0]        tv_r, tv_nxt;
  logic signed [31:0] la_il_r, la_il_nxt, la_vl_r, la_vl_nxt;
  logic signed [31:0] la_ih_r, la_ih_nxt, la_vh_r, la_vh_nxt;
  logic signed [31:0] si_r, si_nxt;

  // working registers of the datapath
  logic signed [31:0] cur_r, cur_nxt, volt_r, volt_nxt, vel_r, vel_nxt;
  logic signed [31:0] tmp_r, tmp_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic signed [67:0] acc_r, acc_nxt;
  logic signed [67:0] prod_r;
  logic [31:0]        mhi_r, mhi_nxt, mlo_r, mlo_nxt;
  logic [31:0]        dv_r, dv_nxt, di_r, di_nxt;
  logic [32:0]        dabs_r, dabs_nxt, k_r, k_nxt;
  logic               sneg_r, sneg_nxt, pass_r, pass_nxt, lo_r, lo_nxt;
  logic               dneg_r, dneg_nxt, qneg_r, qneg_nxt, fast_r, fast_nxt;

  // result word holding register
  logic [2:0]         o_phase_r;
  logic               o_drive_r, o_cmode_r;
  logic [30:0]        o_bw_r, o_res_r, o_ind_r;
  logic signed [31:0] o_cmd_r, o_flux_r;
  logic               o_rev_r;
  logic               load_out;

  // shared multiplier, product registered every cycle
  logic signed [33:0] mul_a, mul_b;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    phase_t             ph;
    logic signed [31:0] ema_v;
    logic signed [31:0] den_r0;
    logic [31:0]        avolt;
    logic signed [69:0] sq;
    logic signed [32:0] avel;
    logic signed [33:0] errw, lim;
    logic signed [67:0] mag68;
    logic [67:0]        ssum;
    logic [51:0]        rr;
    logic signed [69:0] st70;
    logic signed [67:0] fl16;
    logic signed [68:0] num;
    logic [47:0]        anum;
    logic [31:0]        avelu;
    logic signed [32:0] diff, dvs, dis;
    logic [32:0]        mag33;
    logic signed [33:0] fsum;
    logic [45:0]        tvw;
    logic signed [31:0] rmin;

    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    load_out      = 1'b0;
    elapsed_nxt   = elapsed_r;
    res_nxt       = res_r;
    ind_nxt       = ind_r;
    flux_nxt      = flux_r;
    rev_nxt       = rev_r;
    cmd_nxt       = cmd_r;
    tv_nxt        = tv_r;
    la_il_nxt     = la_il_r;
    la_vl_nxt     = la_vl_r;
    la_ih_nxt     = la_ih_r;
    la_vh_nxt     = la_vh_r;
    si_nxt        = si_r;
    cur_nxt       = cur_r;
    volt_nxt      = volt_r;
    vel_nxt       = vel_r;
    tmp_nxt       = tmp_r;
    err_nxt       = err_r;
    acc_nxt       = acc_r;
    mhi_nxt       = mhi_r;
    mlo_nxt       = mlo_r;
    dv_nxt        = dv_r;
    di_nxt        = di_r;
    dabs_nxt      = dabs_r;
    k_nxt         = k_r;
    sneg_nxt      = sneg_r;
    pass_nxt      = pass_r;
    lo_nxt        = lo_r;
    dneg_nxt      = dneg_r;
    qneg_nxt      = qneg_r;
    fast_nxt      = fast_r;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;

    ema_v  = ema_fin(acc_r, prod_r);
    den_r0 = (cur_r > MIN_Q) ? cur_r : MIN_Q;
    avolt  = volt_r[31] ? 32'(-volt_r) : volt_r;
    sq     = qneg_r ? -$signed({6'd0, div_rsp.quot}) : $signed({6'd0, div_rsp.quot});
    avel   = vel_r[31] ? -{vel_r[31], vel_r} : {vel_r[31], vel_r};
    lim    = $signed({4'd0, prod_r[67:38]});
    errw   = $signed({3'd0, test_vel_r}) - {avel[32], avel};
    mag68  = prod_r[67] ? -prod_r : prod_r;
    ssum   = 68'(acc_r) + {36'd0, prod_r[63:32]};
    rr     = ssum[67:16];
    st70   = sneg_r ? -$signed({18'd0, rr}) : $signed({18'd0, rr});
    fl16   = (prod_r + 68'sd32768) >>> 16;
    num    = {{37{volt_r[31]}}, volt_r} - {fl16[67], fl16};
    anum   = num[68] ? 48'(-num) : num[47:0];
    avelu  = avel[31:0];
    diff   = {tmp_r[31], tmp_r} - {flux_r[31], flux_r};
    mag33  = prod_r[64:32];
    fsum   = dneg_r ? ({{2{flux_r[31]}}, flux_r} - $signed({1'b0, mag33}))
                    : ({{2{flux_r[31]}}, flux_r} + $signed({1'b0, mag33}));
    dvs    = {la_vl_r[31], la_vl_r} - {la_vh_r[31], la_vh_r};
    dis    = {la_il_r[31], la_il_r} - {la_ih_r[31], la_ih_r};
    tvw    = prod_r[61:16];
    rmin   = (res_r > MIN_Q) ? res_r : MIN_Q;
    ph     = phase_r;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          cur_nxt  = in_if.current_fb;
          volt_nxt = in_if.voltage_fb;
          vel_nxt  = in_if.velocity_fb;
          ph = in_if.enable ? phase_r : PH_IDLE;
          if (in_if.op && ph == PH_WAIT1) ph = PH_RES;
          else if (in_if.op && ph == PH_WAIT2) ph = PH_FLUX;
          phase_nxt = ph;
          case (ph)
            PH_IDLE: begin
              // idle clears the timer and the command and resets all estimates
              elapsed_nxt = '0;
              cmd_nxt     = '0;
              res_nxt     = RES_RESET;
              ind_nxt     = IND_RESET;
              flux_nxt    = FLUX_RESET;
              rev_nxt     = 1'b0;
              phase_nxt   = in_if.enable ? PH_WAIT1 : PH_IDLE;
              state_nxt   = ST_PUSH;
            end
            PH_RES:  state_nxt = ST_R0;
            PH_IND:  state_nxt = ST_I0;
            PH_FLUX: state_nxt = ST_F0;
            default: state_nxt = ST_PUSH;
          endcase
        end
      end

      ST_PUSH: begin
        if (!out_valid_r || out_if.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      // ---- resistance: filtered V/I at the test current ----
      ST_R0: begin
        cmd_nxt       = $signed({1'b0, test_cur_r});
        qneg_nxt      = volt_r[31];
        div_req.start = 1'b1;
        div_req.num   = {16'd0, avolt, 16'd0};
        div_req.den   = {16'd0, den_r0};
        state_nxt     = ST_R1;
      end
      ST_R1: begin
        mul_a = {{2{res_r[31]}}, res_r};
        mul_b = FILT_KEEP;
        if (div_rsp.done) begin
          tmp_nxt   = sat32(sq);
          state_nxt = ST_R2;
        end
      end
      ST_R2: begin
        acc_nxt   = prod_r;
        mul_a     = {{2{tmp_r[31]}}, tmp_r};
        mul_b     = FILT_NEW;
        state_nxt = ST_R3;
      end
      ST_R3: begin
        res_nxt     = ema_v[31] ? '0 : ema_v;
        elapsed_nxt = tmr_add(elapsed_r, tick_r);
        state_nxt   = (elapsed_nxt >= T_RES) ? ST_R4 : ST_PUSH;
      end
      ST_R4: begin
        mul_a     = {3'd0, test_cur_r};
        mul_b     = {{2{rmin[31]}}, rmin};
        state_nxt = ST_R5;
      end
      ST_R5: begin
        // test voltage limited to half the bus
        tv_nxt      = (tvw > {16'd0, bus_r[30:1]}) ? {1'b0, bus_r[30:1]} : tvw[30:0];
        elapsed_nxt = '0;
        la_il_nxt   = '0;
        la_vl_nxt   = '0;
        phase_nxt   = PH_IND;
        state_nxt   = ST_PUSH;
      end

      // ---- inductance: square wave, averaged levels ----
      ST_I0: begin
        lo_nxt    = (cmd_r < $signed({1'b0, tv_r}));
        mul_a     = lo_nxt ? {{2{la_il_r[31]}}, la_il_r} : {{2{la_ih_r[31]}}, la_ih_r};
        mul_b     = FILT_KEEP;
        state_nxt = ST_I1;
      end
      ST_I1: begin
        acc_nxt   = prod_r;
        mul_a     = {{2{cur_r[31]}}, cur_r};
        mul_b     = FILT_NEW;
        state_nxt = ST_I2;
      end
      ST_I2: begin
        if (lo_r) la_il_nxt = ema_v;
        else      la_ih_nxt = ema_v;
        mul_a     = lo_r ? {{2{la_vl_r[31]}}, la_vl_r} : {{2{la_vh_r[31]}}, la_vh_r};
        mul_b     = FILT_KEEP;
        state_nxt = ST_I3;
      end
      ST_I3: begin
        acc_nxt   = prod_r;
        mul_a     = {{2{volt_r[31]}}, volt_r};
        mul_b     = FILT_NEW;
        state_nxt = ST_I4;
      end
      ST_I4: begin
        if (lo_r) begin
          la_vl_nxt = ema_v;
          cmd_nxt   = $signed({1'b0, tv_r}) + $signed({2'd0, tv_r[30:1]});
        end else begin
          la_vh_nxt = ema_v;
          cmd_nxt   = $signed({2'd0, tv_r[30:1]});
        end
        elapsed_nxt = tmr_add(elapsed_r, tick_r);
        state_nxt   = (elapsed_nxt >= T_IND) ? ST_I5 : ST_PUSH;
      end
      ST_I5: begin
        dv_nxt = dvs[32] ? 32'(-dvs) : dvs[31:0];
        di_nxt = dis[32] ? 32'(-dis) : dis[31:0];
        if (dis == '0) begin
          // no current step: inductance pegs at full scale
          ind_nxt     = I31MAX;
          elapsed_nxt = '0;
          cmd_nxt     = '0;
          si_nxt      = '0;
          phase_nxt   = PH_WAIT2;
          state_nxt   = ST_PUSH;
        end else begin
          state_nxt = ST_I6;
        end
      end
      ST_I6: begin
        mul_a     = {2'd0, dv_r};
        mul_b     = {2'd0, tick_r};
        state_nxt = ST_I7;
      end
      ST_I7: begin
        div_req.start = 1'b1;
        div_req.num   = prod_r[63:0];
        div_req.den   = {di_r, 16'd0};
        state_nxt     = ST_I8;
      end
      ST_I8: begin
        if (div_rsp.done) begin
          ind_nxt     = (div_rsp.quot > {33'd0, I31MAX}) ? I31MAX : div_rsp.quot[30:0];
          elapsed_nxt = '0;
          cmd_nxt     = '0;
          si_nxt      = '0;
          phase_nxt   = PH_WAIT2;
          state_nxt   = ST_PUSH;
        end
      end

      // ---- flux: speed loop plus filtered back-emf ----
      ST_F0: begin
        // one percent of the target by reciprocal multiplication
        mul_a     = {3'd0, test_vel_r};
        mul_b     = RECIP_100;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        // speed error clamped to one percent of the target
        if (errw > lim) errw = lim;
        if (errw < -lim) errw = -lim;
        err_nxt   = errw[31:0];
        fast_nxt  = ($unsigned(avel) > VEL_MIN);
        pass_nxt  = 1'b0;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        mul_a     = pass_r ? {3'd0, kp_r} : {3'd0, ki_r};
        mul_b     = {{2{err_r[31]}}, err_r};
        state_nxt = ST_F3;
      end
      ST_F3: begin
        sneg_nxt  = prod_r[67];
        mhi_nxt   = mag68[63:32];
        mlo_nxt   = mag68[31:0];
        state_nxt = ST_F4;
      end
      ST_F4: begin
        mul_a     = {2'd0, mhi_r};
        mul_b     = {2'd0, tick_r};
        state_nxt = ST_F5;
      end
      ST_F5: begin
        acc_nxt   = prod_r;
        mul_a     = {2'd0, mlo_r};
        mul_b     = {2'd0, tick_r};
        state_nxt = ST_F6;
      end
      ST_F6: begin
        if (!pass_r) begin
          si_nxt    = sat32(st70 + {{38{si_r[31]}}, si_r});
          pass_nxt  = 1'b1;
          state_nxt = ST_F2;
        end else begin
          cmd_nxt   = sat32(st70 + {{38{si_r[31]}}, si_r});
          state_nxt = fast_r ? ST_F7 : ST_FEND;
        end
      end
      ST_F7: begin
        mul_a     = {{2{cur_r[31]}}, cur_r};
        mul_b     = {{2{res_r[31]}}, res_r};
        state_nxt = ST_F8;
      end
      ST_F8: begin
        qneg_nxt      = num[68] ^ vel_r[31];
        div_req.start = 1'b1;
        div_req.num   = {anum, 16'd0};
        div_req.den   = {16'd0, avelu};
        state_nxt     = ST_F9;
      end
      ST_F9: begin
        if (div_rsp.done) begin
          tmp_nxt       = sat32(sq);
          div_req.start = 1'b1;
          div_req.num   = {16'd0, tick_r, 16'd0};
          div_req.den   = {17'd0, (flux_tc_r == '0) ? 31'd1 : flux_tc_r};
          state_nxt     = ST_F10;
        end
      end
      ST_F10: begin
        if (div_rsp.done) begin
          // filter weight capped at one
          k_nxt     = (div_rsp.quot > K_CAP) ? K_CAP[32:0] : div_rsp.quot[32:0];
          dneg_nxt  = diff[32];
          dabs_nxt  = diff[32] ? 33'(-diff) : diff;
          state_nxt = ST_F11;
        end
      end
      ST_F11: begin
        mul_a     = {1'b0, dabs_r};
        mul_b     = {1'b0, k_r};
        state_nxt = ST_F12;
      end
      ST_F12: begin
        flux_nxt  = fsum[31:0];
        state_nxt = ST_FEND;
      end
      ST_FEND: begin
        elapsed_nxt = tmr_add(elapsed_r, tick_r);
        if (elapsed_nxt >= T_FLUX) begin
          if (flux_r[31]) begin
            flux_nxt = sat32(-{{38{flux_r[31]}}, flux_r});
            rev_nxt  = 1'b1;
          end
          elapsed_nxt = '0;
          cmd_nxt     = '0;
          si_nxt      = '0;
          phase_nxt   = PH_DONE;
        end
        state_nxt = ST_PUSH;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and estimate registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      elapsed_r   <= '0;
      res_r       <= RES_RESET;
      ind_r       <= IND_RESET;
      flux_r      <= FLUX_RESET;
      rev_r       <= 1'b0;
      cmd_r       <= '0;
      tv_r        <= '0;
      la_il_r     <= '0;
      la_vl_r     <= '0;
      la_ih_r     <= '0;
      la_vh_r     <= '0;
      si_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      elapsed_r   <= elapsed_nxt;
      res_r       <= res_nxt;
      ind_r       <= ind_nxt;
      flux_r      <= flux_nxt;
      rev_r       <= rev_nxt;
      cmd_r       <= cmd_nxt;
      tv_r        <= tv_nxt;
      la_il_r     <= la_il_nxt;
      la_vl_r     <= la_vl_nxt;
      la_ih_r     <= la_ih_nxt;
      la_vh_r     <= la_vh_nxt;
      si_r        <= si_nxt;
    end
  end

  // datapath scratch, no reset needed
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    volt_r <= volt_nxt;
    vel_r  <= vel_nxt;
    tmp_r  <= tmp_nxt;
    err_r  <= err_nxt;
    acc_r  <= acc_nxt;
    mhi_r  <= mhi_nxt;
    mlo_r  <= mlo_nxt;
    dv_r   <= dv_nxt;
    di_r   <= di_nxt;
    dabs_r <= dabs_nxt;
    k_r    <= k_nxt;
    sneg_r <= sneg_nxt;
    pass_r <= pass_nxt;
    lo_r   <= lo_nxt;
    dneg_r <= dneg_nxt;
    qneg_r <= qneg_nxt;
    fast_r <= fast_nxt;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_phase_r <= phase_r;
      o_drive_r <= (phase_r == PH_RES) || (phase_r == PH_IND) || (phase_r == PH_FLUX);
      o_cmode_r <= (phase_r == PH_RES) || (phase_r == PH_FLUX);
      o_bw_r    <= (phase_r >= PH_WAIT2) ? BW_HIGH : BW_LOW;
      o_cmd_r   <= cmd_r;
      o_res_r   <= res_r[30:0];
      o_ind_r   <= ind_r;
      o_flux_r  <= flux_r;
      o_rev_r   <= rev_r;
    end
  end

  assign in_if.ready              = (state_r == ST_IDLE);
  assign out_if.valid             = out_valid_r;
  assign out_if.phase             = o_phase_r;
  assign out_if.drive_enable      = o_drive_r;
  assign out_if.current_mode      = o_cmode_r;
  assign out_if.current_bandwidth = o_bw_r;
  assign out_if.q_command         = o_cmd_r;
  assign out_if.resistance        = o_res_r;
  assign out_if.inductance        = o_ind_r;
  assign out_if.flux              = o_flux_r;
  assign out_if.reversed          = o_rev_r;

endmodule

### dv/mpi_checker.sv
// Result checker: watches the three channels, predicts each result word and compares.
module mpi_checker
  import mpi_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  mpi_in_if      in_if,
  mpi_out_if     out_if,
  mpi_cfg_if     cfg_if,
  output int     fails,
  output int     pending,
  output int     words_seen,
  output phase_t model_phase
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    phase_t      ph;
    logic        drv;
    logic        cmode;
    logic [30:0] bw;
    logic [31:0] cmd;
    logic [30:0] res;
    logic [30:0] ind;
    logic [31:0] flx;
    logic        rev;
  } tick_result_t;

  localparam longint ONE_S = 64'd268435456;
  localparam longint LMAX  = 64'sd2147483647;
  localparam longint LMIN  = -64'sd2147483648;

  tick_result_t expected_q[$];

  // configuration copy
  longint tcur, tvel, ki, kp, ftc, vbus, tper;
  // identifier state
  phase_t ph;
  longint elapsed_t, r_est, l_est, f_est, cmd, tvolt, integ;
  longint lvl[4];
  logic   rev;

  function automatic longint clamp32(longint v);
    return v > LMAX ? LMAX : (v < LMIN ? LMIN : v);
  endfunction

  function automatic longint lowpass(longint old, longint x);
    return clamp32((old * 64881 + x * 655 + 32768) >>> 16);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    return clamp32((n * 65536) / d);
  endfunction

  function automatic longint times_tick(longint a, longint b);
    longint     prod;
    bit [63:0]  mag, p, r;
    prod = a * b;
    mag  = prod < 0 ? -prod : prod;
    p    = tper;
    r    = (((mag >> 32) * p) + (((mag & 64'hFFFF_FFFF) * p) >> 32)) >> 16;
    return prod < 0 ? -longint'(r) : longint'(r);
  endfunction

  task automatic step_timer();
    elapsed_t = elapsed_t + (tper >> 4);
    if (elapsed_t > 64'hFFFF_FFFF) elapsed_t = 64'hFFFF_FFFF;
  endtask

  task automatic reset_model();
    tcur = TEST_CURRENT_RST; tvel = TEST_VELOCITY_RST; ki = INTEGRAL_GAIN_RST;
    kp = PROP_GAIN_RST; ftc = FLUX_TC_RST; vbus = BUS_VOLTAGE_RST; tper = TICK_PERIOD_RST;
    ph = PH_IDLE; elapsed_t = 0; r_est = 6554; l_est = 66; f_est = 3604; rev = 0;
    cmd = 0; tvolt = 0; integ = 0;
    foreach (lvl[i]) lvl[i] = 0;
  endtask

  // one control tick; pushes the expected result word
  task automatic predict_tick(logic op, logic en, longint cur, longint volt, longint vel);
    longint den, rr, tv, lim, dvs, dis, avel, err, num, inst, diff;
    bit [63:0] dv, di, q, k, tc, mag;
    tick_result_t e;
    if (!en) ph = PH_IDLE;
    if (op && ph == PH_WAIT1) ph = PH_RES;
    else if (op && ph == PH_WAIT2) ph = PH_FLUX;
    case (ph)
      PH_IDLE: begin
        elapsed_t = 0; cmd = 0; r_est = 6554; l_est = 66; f_est = 3604; rev = 0;
        if (en) ph = PH_WAIT1;
      end
      PH_RES: begin
        den = cur > 655 ? cur : 655;
        cmd = tcur;
        r_est = lowpass(r_est, qdiv(volt, den));
        if (r_est < 0) r_est = 0;
        step_timer();
        if (elapsed_t >= 2 * ONE_S) begin
          rr = r_est > 655 ? r_est : 655;
          tv = (tcur * rr) >> 16;
          lim = vbus >> 1;
          tvolt = tv > lim ? lim : tv;
          elapsed_t = 0; lvl[0] = 0; lvl[1] = 0;
          ph = PH_IND;
        end
      end
      PH_IND: begin
        if (cmd < tvolt) begin
          lvl[0] = lowpass(lvl[0], cur);
          lvl[1] = lowpass(lvl[1], volt);
          cmd = tvolt + tvolt / 2;
        end else begin
          lvl[2] = lowpass(lvl[2], cur);
          lvl[3] = lowpass(lvl[3], volt);
          cmd = tvolt / 2;
        end
        step_timer();
        if (elapsed_t >= ONE_S) begin
          dvs = lvl[1] - lvl[3];
          dis = lvl[0] - lvl[2];
          dv = dvs < 0 ? -dvs : dvs;
          di = dis < 0 ? -dis : dis;
          if (di == 0) l_est = LMAX;
          else begin
            q = (dv * 64'(tper)) / (di << 16);
            l_est = q > 64'(LMAX) ? LMAX : longint'(q);
          end
          elapsed_t = 0; cmd = 0; integ = 0;
          ph = PH_WAIT2;
        end
      end
      PH_FLUX: begin
        lim = tvel / 100;
        avel = vel < 0 ? -vel : vel;
        err = tvel - avel;
        if (err > lim) err = lim;
        if (err < -lim) err = -lim;
        integ = clamp32(integ + times_tick(ki, err));
        cmd = clamp32(times_tick(kp, err) + integ);
        if (avel > 6553) begin
          num  = volt - ((cur * r_est + 32768) >>> 16);
          inst = qdiv(num, vel);
          tc   = ftc != 0 ? ftc : 1;
          k    = (64'(tper) << 16) / tc;
          if (k > 64'h1_0000_0000) k = 64'h1_0000_0000;
          diff = inst - f_est;
          mag  = (64'(diff < 0 ? -diff : diff) * k) >> 32;
          f_est = diff < 0 ? f_est - longint'(mag) : f_est + longint'(mag);
        end
        step_timer();
        if (elapsed_t >= 5 * ONE_S) begin
          if (f_est < 0) begin
            f_est = clamp32(-f_est);
            rev = 1;
          end
          elapsed_t = 0; cmd = 0; integ = 0;
          ph = PH_DONE;
        end
      end
      default: ;
    endcase
    e.ph    = ph;
    e.drv   = (ph == PH_RES || ph == PH_IND || ph == PH_FLUX);
    e.cmode = (ph == PH_RES || ph == PH_FLUX);
    e.bw    = ph >= PH_WAIT2 ? BW_HIGH : BW_LOW;
    e.cmd   = cmd[31:0];
    e.res   = r_est[30:0];
    e.ind   = l_est[30:0];
    e.flx   = f_est[31:0];
    e.rev   = rev;
    expected_q.push_back(e);
  endtask

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_word();
    tick_result_t e;
    if (expected_q.size() == 0) begin
      fails++;
      $display("%0t: result word with nothing expected", $time);
      return;
    end
    e = expected_q.pop_front();
    cmp_field("phase", 32'(e.ph), 32'(out_if.phase));
    cmp_field("drive_enable", 32'(e.drv), 32'(out_if.drive_enable));
    cmp_field("current_mode", 32'(e.cmode), 32'(out_if.current_mode));
    cmp_field("current_bandwidth", 32'(e.bw), 32'(out_if.current_bandwidth));
    cmp_field("q_command", e.cmd, out_if.q_command);
    cmp_field("resistance", 32'(e.res), 32'(out_if.resistance));
    cmp_field("inductance", 32'(e.ind), 32'(out_if.inductance));
    cmp_field("flux", e.flx, out_if.flux);
    cmp_field("reversed", 32'(e.rev), 32'(out_if.reversed));
  endtask

  initial begin
    fails = 0; words_seen = 0; pending = 0;
    reset_model();
    model_phase = ph;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      expected_q.delete();
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_word();
        words_seen++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_t'(cfg_if.index))
          CFG_TEST_CURRENT:  tcur = cfg_if.data[30:0];
          CFG_TEST_VELOCITY: tvel = cfg_if.data[30:0];
          CFG_INTEGRAL_GAIN: ki   = cfg_if.data[30:0];
          CFG_PROP_GAIN:     kp   = cfg_if.data[30:0];
          CFG_FLUX_TC:       ftc  = cfg_if.data[30:0];
          CFG_BUS_VOLTAGE:   vbus = cfg_if.data[30:0];
          CFG_TICK_PERIOD:   tper = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        predict_tick(in_if.op, in_if.enable, longint'(in_if.current_fb),
                     longint'(in_if.voltage_fb), longint'(in_if.velocity_fb));
    end
    pending     <= expected_q.size();
    model_phase <= ph;
  end

endmodule

### dv/tb_top.sv
// Testbench top: clock, reset, stimulus, configuration phases and the verdict.
module tb_top;
  import mpi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic   clk;
  logic   rst_n;
  int     fails, pending, words_seen;
  phase_t model_phase;
  int     sent;       // words accepted by the block
  int     completed;  // identifications that reached done
  bit     calm;       // no idling on either side during this stretch

  mpi_in_if  in_if ();
  mpi_out_if out_if ();
  mpi_cfg_if cfg_if ();

  motor_parameter_identifier_top dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  mpi_checker chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if),
    .fails(fails), .pending(pending), .words_seen(words_seen),
    .model_phase(model_phase)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop; the slowest legal run is well under a tenth of this
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int gap_draw();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // result side: random back-pressure, held high while a word waits
  initial begin
    out_if.ready = 1'b0;
    forever begin
      int g;
      g = gap_draw();
      if (g > 0) begin
        out_if.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
    end
  end

  // one input word; valid only drops when a gap is drawn
  task automatic send_word(logic op, logic en, logic [31:0] cur, logic [31:0] volt,
                           logic [31:0] vel);
    int g;
    g = gap_draw();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.enable      <= en;
    in_if.current_fb  <= cur;
    in_if.voltage_fb  <= volt;
    in_if.velocity_fb <= vel;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_noise();
    send_word($urandom_range(0, 1), $urandom_range(0, 3) != 0, $urandom, $urandom, $urandom);
  endtask

  // config writes only once the block has drained
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);   // margin after the last result word
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] cur, logic [31:0] vel, logic [31:0] ki,
                           logic [31:0] kp, logic [31:0] tc, logic [31:0] vbus,
                           logic [31:0] tp);
    write_reg(CFG_TEST_CURRENT, cur);
    write_reg(CFG_TEST_VELOCITY, vel);
    write_reg(CFG_INTEGRAL_GAIN, ki);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_FLUX_TC, tc);
    write_reg(CFG_BUS_VOLTAGE, vbus);
    write_reg(CFG_TICK_PERIOD, tp);
  endtask

  // small signed value around a centre
  function automatic logic [31:0] near(int centre, int spread);
    return 32'(centre + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // one well-formed identification with random content and a little noise;
  // stage loops are capped since a tiny tick period never ends a stage
  task automatic run_identification(int tcur, int tvel, int cap);
    int n, rohm, sgn;
    rohm = $urandom_range(100, 400000);
    sgn  = $urandom_range(0, 1) ? -1 : 1;
    if ($urandom_range(0, 3) == 0) send_word(1'b0, 1'b0, $urandom, $urandom, $urandom);
    send_word(1'b0, 1'b1, $urandom, $urandom, $urandom);
    repeat ($urandom_range(0, 2)) send_word(1'b0, 1'b1, $urandom, $urandom, $urandom);
    send_word(1'b1, 1'b1, near(tcur, 2000), near(0, 100000), $urandom);
    n = 0;
    while (model_phase == PH_RES && n < cap) begin
      if ($urandom_range(0, 29) == 0) send_noise();
      else if ($urandom_range(0, 7) == 0)
        send_word($urandom_range(0, 1), 1'b1, $urandom, $urandom, $urandom);
      else
        send_word(1'b0, 1'b1, near(tcur, 3000), near((tcur >>> 8) * (rohm >>> 8), 5000),
                  $urandom);
      n++;
    end
    n = 0;
    while (model_phase == PH_IND && n < cap) begin
      if ($urandom_range(0, 29) == 0) send_noise();
      else send_word(1'b0, 1'b1, near(0, 200000), near(0, 2000000), $urandom);
      n++;
    end
    repeat ($urandom_range(0, 2)) send_word(1'b0, 1'b1, $urandom, $urandom, $urandom);
    send_word(1'b1, 1'b1, near(0, 100000), near(0, 500000), near(sgn * tvel, 20000));
    n = 0;
    while (model_phase == PH_FLUX && n < cap) begin
      if ($urandom_range(0, 29) == 0) send_noise();
      else if ($urandom_range(0, 9) == 0)
        send_word(1'b0, 1'b1, $urandom, $urandom, near(0, 8000));
      else
        send_word($urandom_range(0, 1), 1'b1, near(0, 100000),
                  near(sgn * 300000, 400000), near(sgn * tvel, tvel / 50 + 10000));
      n++;
    end
    if (model_phase == PH_DONE) completed++;
    repeat ($urandom_range(1, 3)) send_word($urandom_range(0, 1), 1'b1, $urandom, $urandom,
                                          $urandom);
  endtask

  task automatic run_batch(int words, int tcur, int tvel, int cap);
    int goal;
    goal = sent + words;
    while (sent < goal) begin
      calm = $urandom_range(0, 4) == 0;
      if ($urandom_range(0, 5) == 0) repeat (5) send_noise();
      else run_identification(tcur, tvel, cap);
    end
    calm = 1'b0;
  endtask

  initial begin
    int tc, tv;
    sent = 0; completed = 0; calm = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0; in_if.op = 1'b0; in_if.enable = 1'b0;
    in_if.current_fb = '0; in_if.voltage_fb = '0; in_if.velocity_fb = '0;
    cfg_if.valid = 1'b0; cfg_if.index = CFG_TEST_CURRENT; cfg_if.data = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, extreme field values, op in every phase up to flux
    send_word(1'b1, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_word(1'b0, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_word(1'b1, 1'b1, 32'h0, 32'h7fff_ffff, 32'h0);              // start, tiny current
    send_word(1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);  // negative R
    send_word(1'b1, 1'b1, 32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000);
    send_word(1'b0, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);  // disable
    write_reg(CFG_TICK_PERIOD, 32'hffff_ffff);   // just under one second per tick
    send_word(1'b0, 1'b1, 32'h0, 32'h0, 32'h0);
    send_word(1'b1, 1'b1, 32'h0002_0000, 32'h0000_0ccd, 32'h0);
    send_word(1'b0, 1'b1, 32'h0002_0000, 32'h0000_0ccd, 32'h0);  // second resistance tick
    send_word(1'b0, 1'b1, 32'h0001_0000, 32'h0000_1000, 32'h0);  // closes resistance, into inductance
    send_word(1'b0, 1'b1, 32'h0, 32'h0, 32'h0);
    send_word(1'b1, 1'b1, 32'h0, 32'h7fff_ffff, 32'h0000_1999);  // closes inductance with equal levels: zero dI
    send_word(1'b0, 1'b1, 32'h0, 32'h7fff_ffff, 32'h0000_199a);
    send_word(1'b0, 1'b1, 32'h0, 32'h8000_0000, 32'h8000_0000);
    send_word(1'b0, 1'b1, 32'h0, 32'h8000_0000, 32'h7fff_ffff);
    send_word(1'b1, 1'b1, 32'h0, 32'h8000_0000, 32'h0001_0000);
    send_word(1'b0, 1'b1, 32'h0, 32'h8000_0000, 32'h0001_0000);  // still flux
    send_word(1'b1, 1'b1, 32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f);
    send_word(1'b0, 1'b0, 32'h0, 32'h0, 32'h0);

    // settings: typical, all maxima, all minima, then random ones
    write_all(32'h0002_0000, 32'h0032_0000, 32'h0002_0000, 32'h0014_0000,
              32'h0001_0000, 32'h0018_0000, 32'h2000_0000);
    run_batch(80, 32'h0002_0000, 32'h0032_0000, 40);
    write_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    run_batch(40, 32'h7fff_0000, 32'h7fff_0000, 40);
    write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h1);
    run_batch(20, 0, 0, 4);
    repeat (4) begin
      tc = $urandom_range(1, 4) << $urandom_range(12, 18);
      tv = $urandom_range(1, 100) << 16;
      write_all(tc, tv, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20),
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 24),
                $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1 << 18),
                $urandom, $urandom_range(32'h1000_0000, 32'hffff_ffff));
      run_batch(90, tc, tv, 60);
    end

    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    $display("Sent %0d tick words over %0d settings; %0d result words checked.",
             sent, 7, words_seen);
    $display("%0d identification runs reached the done phase.", completed);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
sv/mpi_pkg.sv
sv/mpi_if.sv
sv/mpi_div.sv
sv/motor_parameter_identifier_top.sv
dv/mpi_checker.sv
dv/tb_top.sv
